// ===== src/rpb_pkg.sv =====
// Package for the RGB pixel blend unit: blend mode codes, field widths and
// the rounded divide-by-255 helper shared by the datapath.
// No dependencies.
package rpb_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned OFS_W    = 9;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned IDX_W    = 3;

    localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUBTRACT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GAIN     = 3'd5;

    localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFS_C0 = 3'd1;
    localparam logic [IDX_W-1:0] REG_OFS_C1 = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFS_C2 = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN_C0 = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAIN_C1 = 3'd5;
    localparam logic [IDX_W-1:0] REG_GAIN_C2 = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

    typedef logic [CHAN_W-1:0] t_chan;

    // Rounded n / 255 for n up to 65152 (8-bit result). The quotient estimate
    // x * 257 / 2^16 is low by at most one; one remainder compare corrects it.
    function automatic t_chan div255_round(input logic [17:0] n);
        logic [17:0] x;
        logic [25:0] t;
        logic [8:0]  q0;
        logic [17:0] qm;
        logic [17:0] r;
        logic [8:0]  q;
        x  = n + 18'd127;
        t  = {x, 8'b0} + {8'b0, x};
        q0 = t[24:16];
        qm = {1'b0, q0, 8'b0} - {9'b0, q0};
        r  = x - qm;
        q  = (r >= 18'd255) ? (q0 + 9'd1) : q0;
        return q[7:0];
    endfunction

endpackage

// ===== src/rpb_channel.sv =====
// One color channel of the blend datapath: a shared 8x16 multiplier, the
// rounded divide by 255, clamping and the mode select. Uses rpb_pkg.
module rpb_channel (
    input  logic [rpb_pkg::MODE_W-1:0] i_mode,
    input  rpb_pkg::t_chan             i_a,
    input  rpb_pkg::t_chan             i_b,
    input  logic [rpb_pkg::OFS_W-1:0]  i_offset,
    input  logic [rpb_pkg::GAIN_W-1:0] i_gain,
    output rpb_pkg::t_chan             o_out
);

    logic                  inv;
    rpb_pkg::t_chan        a_sel;
    rpb_pkg::t_chan        b_sel;
    logic [15:0]           m_op;
    logic [23:0]           prod;
    logic [17:0]           n;
    rpb_pkg::t_chan        q;
    rpb_pkg::t_chan        q_out;
    rpb_pkg::t_chan        gain_out;
    logic [8:0]            diff;
    rpb_pkg::t_chan        sub_out;
    logic [9:0]            sum;
    rpb_pkg::t_chan        add_out;

    // Screen and the upper overlay branch work on inverted operands.
    assign inv   = (i_mode == rpb_pkg::MODE_SCREEN) ||
                   ((i_mode == rpb_pkg::MODE_OVERLAY) && i_b[7]);
    assign a_sel = inv ? ~i_a : i_a;
    assign b_sel = inv ? ~i_b : i_b;
    assign m_op  = (i_mode == rpb_pkg::MODE_GAIN) ? i_gain : {8'b0, b_sel};
    assign prod  = {16'b0, a_sel} * {8'b0, m_op};
    assign n     = (i_mode == rpb_pkg::MODE_OVERLAY) ? {1'b0, prod[15:0], 1'b0}
                                                     : {2'b0, prod[15:0]};
    assign q     = rpb_pkg::div255_round(n);
    assign q_out = inv ? ~q : q;

    assign gain_out = (prod[23:16] != 8'd0) ? 8'hFF : prod[15:8];

    assign diff    = {1'b0, i_b} - {1'b0, i_a};
    assign sub_out = diff[8] ? 8'd0 : diff[7:0];

    assign sum     = {2'b0, i_a} + {i_offset[8], i_offset};
    assign add_out = sum[9] ? 8'd0 : (sum[8] ? 8'hFF : sum[7:0]);

    always_comb begin
        case (i_mode)
            rpb_pkg::MODE_MULTIPLY: o_out = q_out;
            rpb_pkg::MODE_SUBTRACT: o_out = sub_out;
            rpb_pkg::MODE_SCREEN:   o_out = q_out;
            rpb_pkg::MODE_OVERLAY:  o_out = q_out;
            rpb_pkg::MODE_ADD:      o_out = add_out;
            rpb_pkg::MODE_GAIN:     o_out = gain_out;
            default:                o_out = i_a;
        endcase
    end

endmodule

// ===== src/rgb_pixel_blend_unit_top.sv =====
// Top level of the RGB pixel blend unit: configuration registers, input and
// result registers with stream handshakes. Uses rpb_pkg and rpb_channel.
//
// Usage: pixel pairs enter on the s_axis channel, tdata carrying a_c0, a_c1,
// a_c2, b_c0, b_c1, b_c2 from the lowest byte up. Blended pixels leave on
// the m_axis channel, tdata carrying out_c0, out_c1, out_c2 from the lowest
// byte up. Each transaction gives exactly one result.
// The accepting edge loads the input register; the blend logic then feeds
// the result register, which loads when empty or when its result is taken.
// Throughput is one pixel per cycle while m_axis_tready stays high, set by
// the single-pass channel datapath. The input register and the result
// register form a two-entry pipeline, so a new pixel is taken while a
// result waits. When the receiver stalls, the result holds and at most
// one further pixel is absorbed before s_axis_tready drops. Configuration
// is written through i_cfg_we, i_cfg_idx and i_cfg_wdata; the user must
// write it only while no pixel is in flight, which the block does not
// enforce. Index 0 is the mode, 1 to 3 the signed offsets, 4 to 6 the 8.8
// gains, and other indexes are ignored. Reset empties the pipeline and
// sets mode multiply, offsets zero and gains 1.0.
module rgb_pixel_blend_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // a_c0, a_c1, a_c2, b_c0, b_c1, b_c2
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_c0, out_c1, out_c2
    input  logic        i_cfg_we,
    input  logic [rpb_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [rpb_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic [rpb_pkg::MODE_W-1:0] r_mode;
    logic [rpb_pkg::OFS_W-1:0]  r_offset [rpb_pkg::NUM_CHAN];
    logic [rpb_pkg::GAIN_W-1:0] r_gain   [rpb_pkg::NUM_CHAN];

    logic        r_s1_vld;
    logic [47:0] r_s1_data;
    logic        r_out_vld;
    logic [23:0] r_out_data;

    logic        out_adv;
    logic        s1_adv;
    logic [23:0] n_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rpb_pkg::MODE_MULTIPLY;
            for (int i = 0; i < rpb_pkg::NUM_CHAN; i++) begin
                r_offset[i] <= '0;
                r_gain[i]   <= rpb_pkg::GAIN_UNITY;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpb_pkg::REG_MODE:    r_mode      <= i_cfg_wdata[2:0];
                rpb_pkg::REG_OFS_C0:  r_offset[0] <= i_cfg_wdata[8:0];
                rpb_pkg::REG_OFS_C1:  r_offset[1] <= i_cfg_wdata[8:0];
                rpb_pkg::REG_OFS_C2:  r_offset[2] <= i_cfg_wdata[8:0];
                rpb_pkg::REG_GAIN_C0: r_gain[0]   <= i_cfg_wdata;
                rpb_pkg::REG_GAIN_C1: r_gain[1]   <= i_cfg_wdata;
                rpb_pkg::REG_GAIN_C2: r_gain[2]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_adv       = !r_out_vld || m_axis_tready;
    assign s1_adv        = r_s1_vld && out_adv;
    assign s_axis_tready = !r_s1_vld || out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_data <= s_axis_tdata;
        end
    end

    for (genvar c = 0; c < rpb_pkg::NUM_CHAN; c++) begin : g_chan
        rpb_channel u_chan (
            .i_mode   (r_mode),
            .i_a      (r_s1_data[8*c +: 8]),
            .i_b      (r_s1_data[8*(c+3) +: 8]),
            .i_offset (r_offset[c]),
            .i_gain   (r_gain[c]),
            .o_out    (n_out_data[8*c +: 8])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_s1_vld && r_out_vld && !m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_s1_vld)
        else $error("accepted transaction not held in the input register");

    a_s1_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("result lost between input and result register");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_adv) |=> (r_s1_vld && $stable(r_s1_data)))
        else $error("pending input changed while the output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_vld && !m_axis_tvalid))
        else $error("pipeline not empty after reset");

endmodule

// ===== tb/tb_rgb_pixel_blend_unit_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rgb_pixel_blend_unit_top: drives pixel pairs through all blend
// modes and register settings, predicts each blended pixel and compares it on the output.
// Depends on rpb_pkg and the rgb_pixel_blend_unit_top RTL.
module tb_rgb_pixel_blend_unit_top;

    localparam logic [rpb_pkg::IDX_W-1:0]  REG_NONE   = 3'd7;
    localparam logic [rpb_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [rpb_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int PHASES           = 16;
    localparam int PHASE_ITEMS      = 60;
    localparam int LONG_HOLD_AT     = 294;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        rpb_pkg::t_chan [rpb_pkg::NUM_CHAN-1:0] b;
        rpb_pkg::t_chan [rpb_pkg::NUM_CHAN-1:0] a;
    } t_pixel_pair;

    typedef rpb_pkg::t_chan [rpb_pkg::NUM_CHAN-1:0] t_blended;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [47:0]                 s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [23:0]                 m_axis_tdata;
    logic                        i_cfg_we      = 1'b0;
    logic [rpb_pkg::IDX_W-1:0]   i_cfg_idx     = '0;
    logic [rpb_pkg::CFG_W-1:0]   i_cfg_wdata   = '0;

    logic [rpb_pkg::MODE_W-1:0]        mode_q;
    logic signed [rpb_pkg::OFS_W-1:0]  ofs_q  [rpb_pkg::NUM_CHAN];
    logic [rpb_pkg::GAIN_W-1:0]        gain_q [rpb_pkg::NUM_CHAN];

    t_pixel_pair pixel_queue[$];
    t_blended    blended_expected[$];
    t_pixel_pair offered_pair;
    t_blended    want;
    t_blended    got;
    int          queued_count   = 0;
    int          accepted_count = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          send_gap       = 0;
    int          recv_stall     = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    logic        hold_off       = 1'b0;
    bit          no_idle        = 1'b0;

    rgb_pixel_blend_unit_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // a_c0, a_c1, a_c2, b_c0, b_c1, b_c2
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_c0, out_c1, out_c2
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int div255_nearest(input int n);
        return (2 * n + 255) / 510;
    endfunction

    function automatic int sat_byte(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function automatic t_blended blend_pixel(input t_pixel_pair px);
        t_blended res;
        int av;
        int bv;
        int gv;
        for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
            av = px.a[ch];
            bv = px.b[ch];
            case (mode_q)
                rpb_pkg::MODE_MULTIPLY: begin
                    res[ch] = rpb_pkg::t_chan'(div255_nearest(av * bv));
                end
                rpb_pkg::MODE_SUBTRACT: begin
                    res[ch] = rpb_pkg::t_chan'(sat_byte(bv - av));
                end
                rpb_pkg::MODE_SCREEN: begin
                    res[ch] = rpb_pkg::t_chan'(255 - div255_nearest((255 - av) * (255 - bv)));
                end
                rpb_pkg::MODE_OVERLAY: begin
                    if (bv <= 127)
                        res[ch] = rpb_pkg::t_chan'(div255_nearest(2 * av * bv));
                    else
                        res[ch] = rpb_pkg::t_chan'(255 -
                                  div255_nearest(2 * (255 - av) * (255 - bv)));
                end
                rpb_pkg::MODE_ADD: begin
                    res[ch] = rpb_pkg::t_chan'(sat_byte(av + int'(ofs_q[ch])));
                end
                rpb_pkg::MODE_GAIN: begin
                    gv = (av * int'(gain_q[ch])) >>> 8;
                    res[ch] = rpb_pkg::t_chan'((gv > 255) ? 255 : gv);
                end
                default:       res[ch] = px.a[ch];
            endcase
        end
        return res;
    endfunction

    function automatic rpb_pkg::t_chan pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return rpb_pkg::t_chan'($urandom);
        endcase
    endfunction

    function automatic logic [rpb_pkg::OFS_W-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0:       return 9'h0FF;
            1:       return 9'h101;
            2:       return 9'h100;
            default: return rpb_pkg::OFS_W'($urandom);
        endcase
    endfunction

    function automatic logic [rpb_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return rpb_pkg::GAIN_UNITY;
            5:       return rpb_pkg::GAIN_W'($urandom);
            default: return rpb_pkg::GAIN_W'($urandom_range(0, 511));
        endcase
    endfunction

    task automatic write_reg(input logic [rpb_pkg::IDX_W-1:0] idx,
                             input logic [rpb_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            rpb_pkg::REG_MODE: begin
                mode_q = val[rpb_pkg::MODE_W-1:0];
            end
            rpb_pkg::REG_OFS_C0, rpb_pkg::REG_OFS_C1, rpb_pkg::REG_OFS_C2: begin
                ofs_q[idx - rpb_pkg::REG_OFS_C0] = val[rpb_pkg::OFS_W-1:0];
            end
            rpb_pkg::REG_GAIN_C0, rpb_pkg::REG_GAIN_C1, rpb_pkg::REG_GAIN_C2: begin
                gain_q[idx - rpb_pkg::REG_GAIN_C0] = val;
            end
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_pair(input t_pixel_pair px);
        pixel_queue = {pixel_queue, px};
        queued_count++;
    endtask

    // The block is idle once every queued pair has been accepted and its result received.
    task automatic wait_idle();
        @(posedge i_clk);
        while (accepted_count != queued_count || blended_expected.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                blended_expected = {blended_expected, blend_pixel(offered_pair)};
                accepted_count++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    offered_pair = pixel_queue.pop_front();
                    s_axis_tdata  <= offered_pair;
                    s_axis_tvalid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 4);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // A long hold-off lets the sender fill the pipeline and stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left = 0;
            hold_done = 1'b0;
            hold_off  <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= LONG_HOLD_AT) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            hold_off <= (hold_left > 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (blended_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result %h at cycle %0d.", m_axis_tdata, cycle_count);
                end else begin
                    want = blended_expected.pop_front();
                    got  = m_axis_tdata;
                    for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
                        if (got[ch] !== want[ch]) begin
                            mismatches++;
                            if (mismatches <= MAX_REPORTS)
                                $display("Result %0d out_c%0d: expected %0d, got %0d.",
                                         results_seen, ch, want[ch], got[ch]);
                        end
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        t_pixel_pair                corner_pairs [3];
        logic [rpb_pkg::MODE_W-1:0] corner_modes [8];
        t_pixel_pair                px;
        logic [rpb_pkg::MODE_W-1:0] mode_pick;

        mode_q = rpb_pkg::MODE_MULTIPLY;
        for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
            ofs_q[ch]  = '0;
            gain_q[ch] = rpb_pkg::GAIN_UNITY;
        end
        corner_modes = '{rpb_pkg::MODE_MULTIPLY, rpb_pkg::MODE_SUBTRACT,
                         rpb_pkg::MODE_SCREEN, rpb_pkg::MODE_OVERLAY,
                         rpb_pkg::MODE_ADD, rpb_pkg::MODE_GAIN, MODE_RSVD6, MODE_RSVD7};
        // Fields from the top: b_c2, b_c1, b_c0, a_c2, a_c1, a_c0.
        corner_pairs[0] = {8'd255, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0};
        corner_pairs[1] = {8'd128, 8'd127, 8'd0,   8'd128, 8'd0,   8'd255};
        corner_pairs[2] = {8'd254, 8'd128, 8'd127, 8'd1,   8'd77,  8'd200};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A write to an index past the register list must change nothing.
        write_reg(REG_NONE, 16'hFFFF);
        foreach (corner_modes[m]) begin
            wait_idle();
            if (corner_modes[m] == rpb_pkg::MODE_ADD) begin
                write_reg(rpb_pkg::REG_OFS_C0, 16'h00FF);
                write_reg(rpb_pkg::REG_OFS_C1, 16'h0101);
                write_reg(rpb_pkg::REG_OFS_C2, 16'h0100);
            end
            if (corner_modes[m] == rpb_pkg::MODE_GAIN) begin
                write_reg(rpb_pkg::REG_GAIN_C0, 16'h0000);
                write_reg(rpb_pkg::REG_GAIN_C1, 16'hFFFF);
                write_reg(rpb_pkg::REG_GAIN_C2, 16'h0180);
            end
            write_reg(rpb_pkg::REG_MODE, {13'd0, corner_modes[m]});
            foreach (corner_pairs[k])
                queue_pair(corner_pairs[k]);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            no_idle = (ph % 4 == 1);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_NONE, rpb_pkg::CFG_W'($urandom));
            for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
                write_reg(rpb_pkg::REG_OFS_C0 + rpb_pkg::IDX_W'(ch),
                          {7'($urandom), pick_offset()});
                write_reg(rpb_pkg::REG_GAIN_C0 + rpb_pkg::IDX_W'(ch), pick_gain());
            end
            if (ph < 8)
                mode_pick = corner_modes[ph];
            else
                mode_pick = rpb_pkg::MODE_W'($urandom_range(rpb_pkg::MODE_MULTIPLY,
                                                            rpb_pkg::MODE_GAIN));
            write_reg(rpb_pkg::REG_MODE, {13'($urandom), mode_pick});
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                for (int ch = 0; ch < rpb_pkg::NUM_CHAN; ch++) begin
                    px.a[ch] = pick_chan();
                    px.b[ch] = pick_chan();
                end
                queue_pair(px);
            end
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && blended_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rpb_pkg.sv
src/rpb_channel.sv
src/rgb_pixel_blend_unit_top.sv
tb/tb_rgb_pixel_blend_unit_top.sv
